// ===== design/wide_integer_alu_unit_defines.svh =====
// assertion macros for the wide integer alu unit
// no dependencies
`ifndef WIDE_INTEGER_ALU_UNIT_DEFINES_SVH
`define WIDE_INTEGER_ALU_UNIT_DEFINES_SVH
`define WIA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define WIA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== design/wia_pkg.sv =====
// shared types and command codes for the wide integer alu unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wia_pkg;
  localparam int unsigned DATA_W = 128;
  localparam int unsigned HALF_W = 64;
  localparam int unsigned CMD_W = 5;
  localparam int unsigned MUL_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 5'd0, CMD_SUB = 5'd1, CMD_MUL = 5'd2, CMD_DIV = 5'd3, CMD_MOD = 5'd4,
    CMD_NEG = 5'd5, CMD_INC = 5'd6, CMD_DEC = 5'd7, CMD_SHL = 5'd8, CMD_SHR = 5'd9,
    CMD_ROL = 5'd10, CMD_ROR = 5'd11, CMD_EQ = 5'd12, CMD_NE = 5'd13, CMD_LT = 5'd14,
    CMD_LE = 5'd15, CMD_GT = 5'd16, CMD_GE = 5'd17, CMD_AND = 5'd18, CMD_OR = 5'd19,
    CMD_NOT = 5'd20, CMD_XOR = 5'd21, CMD_NAND = 5'd22, CMD_NOR = 5'd23,
    CMD_XNOR = 5'd24
  } cmd_t;

  // one item as it rides down the chain
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] rem;   // partial remainder
    logic [DATA_W-1:0] quo;   // quotient, dividend bits shift out of its top
    logic [DATA_W-1:0] acc;   // product accumulator
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] rem;
    logic              flag;
  } result_t;
endpackage
`default_nettype wire

// ===== design/wia_cell.sv =====
// one cell of the chain: one restoring divide step; on the first sixteen
// cells also a 32x32 partial product if it fits 128 bits; depends on wia_pkg
`timescale 1ns / 1ps
`default_nettype none
module wia_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wia_pkg::item_t      din,
  output wia_pkg::item_t      dout
);
  import wia_pkg::*;
  localparam int unsigned LANES = DATA_W / MUL_W;

  logic [DATA_W:0]    trial;
  logic [DATA_W:0]    diff;
  logic [DATA_W-1:0]  pp;
  item_t              nxt;

  always_comb begin
    nxt = din;
    trial = {din.rem, din.quo[DATA_W-1]};
    diff = trial - {1'b0, din.b};
    nxt.quo = {din.quo[DATA_W-2:0], ~diff[DATA_W]};
    nxt.rem = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
    pp = '0;
    if (INDEX < LANES * LANES) begin
      if ((INDEX / LANES) + (INDEX % LANES) < LANES) begin
        pp = DATA_W'({MUL_W'(din.a >> (MUL_W * (INDEX / LANES)))}
             * {MUL_W'(din.b >> (MUL_W * (INDEX % LANES)))})
             << (MUL_W * ((INDEX / LANES) + (INDEX % LANES)));
      end
      nxt.acc = din.acc + pp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/wia_final.sv =====
// last stage: picks the result for the command; depends on wia_pkg
`timescale 1ns / 1ps
`default_nettype none
module wia_final (
  input  wia_pkg::item_t   din,
  output wia_pkg::result_t dout
);
  import wia_pkg::*;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic              lt_ab;
  logic              lt_ba;
  logic              eq_ab;

  always_comb begin
    a = din.a;
    b = din.b;
    lt_ab = a < b;
    lt_ba = b < a;
    eq_ab = a == b;
    dout = '0;
    unique case (din.cmd)
      CMD_ADD:  dout.res = a + b;
      CMD_SUB:  dout.res = a - b;
      CMD_MUL:  dout.res = din.acc;
      CMD_DIV:  begin
        dout.res = din.quo;
        dout.rem = din.rem;
      end
      CMD_MOD:  dout.res = din.rem;
      CMD_NEG:  dout.res = '0 - a;
      CMD_INC:  dout.res = a + DATA_W'(1);
      CMD_DEC:  dout.res = a - DATA_W'(1);
      CMD_SHL:  dout.res = {a[DATA_W-2:0], 1'b0};
      CMD_SHR:  dout.res = {1'b0, a[DATA_W-1:1]};
      CMD_ROL:  dout.res = {a[DATA_W-2:0], a[DATA_W-1]};
      CMD_ROR:  dout.res = {a[0], a[DATA_W-1:1]};
      CMD_EQ:   dout.flag = eq_ab;
      CMD_NE:   dout.flag = !eq_ab;
      CMD_LT:   dout.flag = lt_ab;
      CMD_LE:   dout.flag = !lt_ba;
      CMD_GT:   dout.flag = lt_ba;
      CMD_GE:   dout.flag = !lt_ab;
      CMD_AND:  dout.res = a & b;
      CMD_OR:   dout.res = a | b;
      CMD_NOT:  dout.res = ~a;
      CMD_XOR:  dout.res = a ^ b;
      CMD_NAND: dout.res = ~(a & b);
      CMD_NOR:  dout.res = ~(a | b);
      CMD_XNOR: dout.res = ~(a ^ b);
      default:  dout = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/wide_integer_alu_unit.sv =====
// top level of the wide integer alu unit: a chain of 128 cells and an output stage
// depends on wia_pkg, wia_cell, wia_final and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "wide_integer_alu_unit_defines.svh"
// Takes one command every cycle while the output is not held. Every
// command, simple or not, runs down a chain of 128 register cells, one
// restoring divide step per cell (of the first sixteen cells, those whose
// product fits in 128 bits also add one 32x32 partial product), then one
// output register. The first cell captures the item at the input transfer.
// The chain is a stalling pipeline: when the output is held, the whole
// chain holds, and a new item enters whenever the chain moves.
module wide_integer_alu_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid_in,
  output logic             ready_in,
  input  wire logic [4:0]  command,
  input  wire logic [63:0] a_low,
  input  wire logic [63:0] a_high,
  input  wire logic [63:0] b_low,
  input  wire logic [63:0] b_high,
  output logic             valid_out,
  input  wire logic        ready_out,
  output logic [63:0]      result_low,
  output logic [63:0]      result_high,
  output logic [63:0]      remainder_low,
  output logic [63:0]      remainder_high,
  output logic             flag
);
  import wia_pkg::*;
  localparam int unsigned STAGES = DATA_W;

  item_t             chain [STAGES+1];
  logic [STAGES-1:0] vld;
  logic              adv;
  result_t           fin;
  result_t           out_r;

  // the whole chain moves when the output slot frees or is empty
  assign adv = !valid_out || ready_out;
  assign ready_in = adv;

  assign chain[0] = '{cmd: command, a: {a_high, a_low}, b: {b_high, b_low},
                      rem: '0, quo: {a_high, a_low}, acc: '0};

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    wia_cell #(.INDEX(i)) u_cell (
      .clk(clk), .en(adv), .din(chain[i]), .dout(chain[i+1])
    );
  end

  // vld[i] marks the item held in cell i
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], valid_in};
    end
  end

  wia_final u_final (.din(chain[STAGES]), .dout(fin));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= vld[STAGES-1];
    end
    if (adv) begin
      out_r <= fin;
    end
  end

  assign result_low     = out_r.res[HALF_W-1:0];
  assign result_high    = out_r.res[DATA_W-1:HALF_W];
  assign remainder_low  = out_r.rem[HALF_W-1:0];
  assign remainder_high = out_r.rem[DATA_W-1:HALF_W];
  assign flag           = out_r.flag;

  `WIA_ASSERT_NEXT(a_hold, clk, rst, valid_out && !ready_out, valid_out && $stable(out_r))
  `WIA_ASSERT_IMP(a_ready, clk, rst, !valid_out, ready_in)
  `WIA_ASSERT_IMP(a_flag, clk, rst, valid_out && flag, out_r.res == '0 && out_r.rem == '0)
endmodule
`default_nettype wire

// ===== dv/wide_integer_alu_unit_checker.sv =====
// checker for the wide integer alu unit: watches both channels, predicts and compares
// depends on wia_pkg
`timescale 1ns / 1ps
module wide_integer_alu_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  input  logic        ready_in,
  input  logic [4:0]  command,
  input  logic [63:0] a_low,
  input  logic [63:0] a_high,
  input  logic [63:0] b_low,
  input  logic [63:0] b_high,
  input  logic        valid_out,
  input  logic        ready_out,
  input  logic [63:0] result_low,
  input  logic [63:0] result_high,
  input  logic [63:0] remainder_low,
  input  logic [63:0] remainder_high,
  input  logic        flag,
  output int          errors,
  output int          pending
);
  import wia_pkg::*;

  typedef struct packed {
    logic [127:0] res;
    logic [127:0] rem;
    logic         flag;
  } alu_answer_t;

  alu_answer_t answers_q[$];

  // restoring division with the full-width compare, 129-bit partial remainder
  function automatic void divide128(input logic [127:0] n, input logic [127:0] d,
                                    output logic [127:0] q, output logic [127:0] r);
    logic [128:0] part;
    part = '0;
    q = '0;
    for (int i = 127; i >= 0; i--) begin
      part = {part[127:0], n[i]};
      if (part >= {1'b0, d}) begin
        part = part - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    r = part[127:0];
  endfunction

  function automatic alu_answer_t compute_answer(input logic [4:0] op,
                                                 input logic [127:0] a,
                                                 input logic [127:0] b);
    alu_answer_t ans;
    logic [127:0] q, r;
    ans = '0;
    case (op)
      CMD_ADD:  ans.res = a + b;
      CMD_SUB:  ans.res = a - b;
      CMD_MUL:  ans.res = a * b;
      CMD_DIV:  begin divide128(a, b, q, r); ans.res = q; ans.rem = r; end
      CMD_MOD:  begin divide128(a, b, q, r); ans.res = r; end
      CMD_NEG:  ans.res = -a;
      CMD_INC:  ans.res = a + 1;
      CMD_DEC:  ans.res = a - 1;
      CMD_SHL:  ans.res = a << 1;
      CMD_SHR:  ans.res = a >> 1;
      CMD_ROL:  ans.res = {a[126:0], a[127]};
      CMD_ROR:  ans.res = {a[0], a[127:1]};
      CMD_EQ:   ans.flag = (a == b);
      CMD_NE:   ans.flag = (a != b);
      CMD_LT:   ans.flag = (a < b);
      CMD_LE:   ans.flag = (a <= b);
      CMD_GT:   ans.flag = (a > b);
      CMD_GE:   ans.flag = (a >= b);
      CMD_AND:  ans.res = a & b;
      CMD_OR:   ans.res = a | b;
      CMD_NOT:  ans.res = ~a;
      CMD_XOR:  ans.res = a ^ b;
      CMD_NAND: ans.res = ~(a & b);
      CMD_NOR:  ans.res = ~(a | b);
      CMD_XNOR: ans.res = ~(a ^ b);
      default:  ans = '0;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    alu_answer_t want, got;
    if (rst) begin
      errors <= 0;
      answers_q.delete();
    end else begin
      if (valid_out && ready_out) begin
        got = {result_high, result_low, remainder_high, remainder_low, flag};
        if (answers_q.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer at %0t", $realtime);
          errors <= errors + 1;
        end else begin
          want = answers_q.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("mismatch: res %h/%h rem %h/%h flag %b/%b (exp/act)",
                       want.res, got.res, want.rem, got.rem, want.flag, got.flag);
            errors <= errors + 1;
          end
        end
      end
      if (valid_in && ready_in)
        answers_q.push_back(compute_answer(command, {a_high, a_low}, {b_high, b_low}));
    end
    pending = answers_q.size();
  end
endmodule

// ===== dv/wide_integer_alu_unit_tb.sv =====
// testbench top for the wide integer alu unit: stimulus, clock, reset and verdict
// depends on wia_pkg, the block and wide_integer_alu_unit_checker
`timescale 1ns / 1ps
module wide_integer_alu_unit_tb;
  import wia_pkg::*;

  localparam int LATENCY = 128;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid_in = 1'b0;
  logic [4:0]  command = '0;
  logic [63:0] a_low = '0, a_high = '0, b_low = '0, b_high = '0;
  logic        ready_out = 1'b0;
  logic        ready_in, valid_out, flag;
  logic [63:0] result_low, result_high, remainder_low, remainder_high;
  int          errors, pending;
  int          cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  wide_integer_alu_unit uut (
    .clk, .rst, .valid_in, .ready_in, .command, .a_low, .a_high, .b_low, .b_high,
    .valid_out, .ready_out, .result_low, .result_high, .remainder_low,
    .remainder_high, .flag
  );

  wide_integer_alu_unit_checker checker_i (
    .clk, .rst, .valid_in, .ready_in, .command, .a_low, .a_high, .b_low, .b_high,
    .valid_out, .ready_out, .result_low, .result_high, .remainder_low,
    .remainder_high, .flag, .errors, .pending
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // operand shapes that hit carries, zero divisors and equal operands
  function automatic logic [127:0] shaped_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 128'd1;
      3: return {64'd0, rand64()};
      4: return {rand64(), 64'd0};
      5: return 128'd1 << $urandom_range(0, 127);
      6: return {rand64(), rand64()} >> $urandom_range(0, 127);
      7: return {1'b1, 127'd0};
      default: return {rand64(), rand64()};
    endcase
  endfunction

  // valid drops only when a gap comes before an item, so back to back items keep it high
  task automatic send_item(input logic [4:0] op, input logic [127:0] a,
                           input logic [127:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      valid_in <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid_in <= 1'b1;
    command <= op;
    {a_high, a_low} <= a;
    {b_high, b_low} <= b;
    @(posedge clk);
    while (!ready_in) @(posedge clk);
  endtask

  // output stall pattern runs on its own
  always @(posedge clk) begin
    if (rst) ready_out <= 1'b0;
    else if ($urandom_range(0, 199) == 0) ready_out <= 1'b0;
    else if ($urandom_range(0, 99) < 70) ready_out <= 1'b1;
    else ready_out <= ($urandom_range(0, 1) == 1);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [127:0] x, y;
    logic [4:0]   op;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, division by zero, carries, a no-op code
    send_item(CMD_ADD, '1, 128'd1);
    send_item(CMD_SUB, '0, 128'd1);
    send_item(CMD_MUL, '1, '1);
    send_item(CMD_DIV, {rand64(), rand64()}, '0);
    send_item(CMD_MOD, {rand64(), rand64()}, '0);
    send_item(CMD_DIV, '1, 128'd3);
    send_item(CMD_DIV, {1'b1, 127'd0}, {2'b11, 126'd0});
    send_item(CMD_MOD, '1, {1'b1, 127'd1});
    send_item(CMD_NEG, 128'd1 << 64, '0);
    send_item(CMD_NEG, '0, '0);
    send_item(CMD_INC, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, '0);
    send_item(CMD_DEC, '0, '0);
    send_item(CMD_SHL, {1'b1, 126'd0, 1'b1}, '0);
    send_item(CMD_SHR, {1'b1, 126'd0, 1'b1}, '0);
    send_item(CMD_ROL, {1'b1, 127'd0}, '0);
    send_item(CMD_ROR, 128'd1, '0);
    for (int c = CMD_EQ; c <= CMD_GE; c++) send_item(5'(c), {64'd5, 64'd0}, {64'd5, 64'd0});
    send_item(CMD_AND, '1, '1);
    send_item(CMD_XNOR, '0, '1);
    send_item(5'd31, '1, '1);
    // random part
    for (int n = 0; n < 1550; n++) begin
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(25, 31))
                                        : 5'($urandom_range(0, 24));
      x = shaped_operand();
      y = ($urandom_range(0, 7) == 0) ? x : shaped_operand();
      send_item(op, x, y);
    end
    valid_in <= 1'b0;
    repeat (LATENCY + 20) @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
    if (errors == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
